// ===== design/conv2d_clamp_edge_rgb_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CONV2D_CLAMP_EDGE_RGB_ASSERT_SVH
`define CONV2D_CLAMP_EDGE_RGB_ASSERT_SVH

// Check cons in the same cycle as ante.
`define C2D_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("conv2d port check failed");

// Check cons in the cycle after ante.
`define C2D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("conv2d port check failed");

`endif

// ===== design/c2d_pkg.sv =====
package c2d_pkg;

	localparam int MAX_KERNEL_DEF = 7;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int COEF_FRAC_DEF  = 8;
	localparam int MAX_HEIGHT     = 4096;
	localparam int PIX_MAX        = 255;
	localparam int MAX_OUT        = 4;
	localparam int Q_DEPTH        = 2;

	localparam int OP_W       = 2;
	localparam int CIDX_W     = 6;
	localparam int COEF_W     = 16;
	localparam int PIX_W      = 8;
	localparam int RGB_W      = 3 * PIX_W;
	localparam int COL_OUT_W  = 10;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int KCOLS_RST   = 3;
	localparam int KROWS_RST   = 3;
	localparam int FWIDTH_RST  = 640;
	localparam int FHEIGHT_RST = 480;

	typedef enum logic [OP_W-1:0] {
		OP_COEF  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_DRAIN = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_COEF,
		CMD_PIXEL,
		CMD_DRAIN,
		CMD_NOP
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KCOLS   = 2'd0,
		REG_KROWS   = 2'd1,
		REG_FWIDTH  = 2'd2,
		REG_FHEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [CIDX_W-1:0]        cidx;
		logic signed [COEF_W-1:0] coef;
		logic [RGB_W-1:0]         rgb;
	} qitem_t;

	typedef struct packed {
		logic [COL_OUT_W-1:0] col;
		logic [ROW_W-1:0]     row;
		logic [PIX_W-1:0]     red;
		logic [PIX_W-1:0]     green;
		logic [PIX_W-1:0]     blue;
		logic                 frame_done;
		logic                 last;
	} result_t;

endpackage

// ===== design/conv2d_clamp_edge_rgb.sv =====
// Streaming RGB 2D convolution with clamp-to-edge borders. Send pixels in raster
// order (op 1), coefficients as op 0 beats (index = row * kernel_cols + column,
// signed Q8.8), and drain beats (op 2) after the frame's last pixel to collect the
// bottom rows. Each input beat yields zero to four result beats; last marks the
// final one and frame_done the frame's final pixel. A register write restarts the
// stream; write registers only while no beat is in flight. The input side queues up
// to two beats; the back end finishes all results of one beat before it takes the
// next, reading one row-buffer word and one coefficient per tap for each result,
// then finishing and handing it off; a result waiting on a stalled output adds its
// wait. The single read port of the row buffer is why taps are read one at a time.
module conv2d_clamp_edge_rgb import c2d_pkg::*; #(
	parameter int MAX_KERNEL     = MAX_KERNEL_DEF,
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input beats
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic [CIDX_W-1:0]        coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic [PIX_W-1:0]         red_in,
	input  logic [PIX_W-1:0]         green_in,
	input  logic [PIX_W-1:0]         blue_in,
	// register writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	// result beats
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COL_OUT_W-1:0]     out_col,
	output logic [ROW_W-1:0]         out_row,
	output logic [PIX_W-1:0]         red_out,
	output logic [PIX_W-1:0]         green_out,
	output logic [PIX_W-1:0]         blue_out,
	output logic                     frame_done,
	output logic                     last
);

	logic    q_valid, q_pop;
	qitem_t  q_item;
	result_t res;

	// Front: accept and classify beats into a two-entry queue.
	c2d_front #(
		.MAX_KERNEL(MAX_KERNEL)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// Back: line buffers, coefficient store and the tap sequencer.
	c2d_back #(
		.MAX_KERNEL    (MAX_KERNEL),
		.MAX_WIDTH     (MAX_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.res      (res),
		.res_valid(out_valid),
		.res_ready(out_ready)
	);

	// Split the registered result onto the ports.
	assign out_col    = res.col;
	assign out_row    = res.row;
	assign red_out    = res.red;
	assign green_out  = res.green;
	assign blue_out   = res.blue;
	assign frame_done = res.frame_done;
	assign last       = res.last;

endmodule

// ===== design/c2d_front.sv =====
module c2d_front import c2d_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic [CIDX_W-1:0]        coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic [PIX_W-1:0]         red_in,
	input  logic [PIX_W-1:0]         green_in,
	input  logic [PIX_W-1:0]         blue_in,
	output logic                     q_valid,
	output qitem_t                   q_item,
	input  logic                     q_pop
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	qitem_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	qitem_t             item;
	logic               push;

	// Classify: out-of-range coefficient writes and unknown ops become no-ops.
	always_comb begin
		item.cidx = coef_index;
		item.coef = coef_value;
		item.rgb  = {red_in, green_in, blue_in};
		unique case (op_t'(op))
			OP_COEF:  item.cmd = (int'(coef_index) < MAX_KERNEL * MAX_KERNEL) ? CMD_COEF : CMD_NOP;
			OP_PIXEL: item.cmd = CMD_PIXEL;
			OP_DRAIN: item.cmd = CMD_DRAIN;
			OP_NONE:  item.cmd = CMD_NOP;
		endcase
	end

	assign in_ready = (count_q != CNT_W'(Q_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(q_pop);
		end
	end

endmodule

// ===== design/c2d_back.sv =====
module c2d_back import c2d_pkg::*; #(
	parameter int MAX_KERNEL     = MAX_KERNEL_DEF,
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_valid,
	input  qitem_t                q_item,
	output logic                  q_pop,
	output result_t               res,
	output logic                  res_valid,
	input  logic                  res_ready
);

	localparam int KW_W     = $clog2(MAX_KERNEL + 1);
	localparam int RING_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int CA_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int CA_W     = (CA_DEPTH > 1) ? $clog2(CA_DEPTH) : 1;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int RA_DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int RA_W     = $clog2(RA_DEPTH);
	localparam int PROD_W   = PIX_W + 1 + COEF_W;
	localparam int ACC_W    = PROD_W + CA_W + 1;
	localparam int CNT_W    = $clog2(MAX_OUT + 1);
	localparam int ROWX_W   = ROW_W + 1;
	localparam int COLX_W   = COL_W + 1;
	localparam int ROWS_W   = ROW_W + 2;
	localparam int COLS_W   = COL_W + 2;
	localparam int DS_W     = KW_W + 1;
	localparam int RS_W     = RING_W + 2;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_TAP, S_WAIT, S_FIN} state_t;

	function automatic int clamp_int(input int v, input int lo, input int hi);
		int r;
		r = (v < lo) ? lo : ((v > hi) ? hi : v);
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W:0] m;
		logic [PIX_W-1:0]      r;
		m = ((ACC_W + 1)'(s) + (ACC_W + 1)'(1 << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
		if (s <= 0) begin
			r = '0;
		end else if (m > (ACC_W + 1)'(PIX_MAX)) begin
			r = PIX_W'(PIX_MAX);
		end else begin
			r = PIX_W'(m);
		end
		return r;
	endfunction

	// Configuration, held already clamped.
	logic [KW_W-1:0]   kw_q, kh_q;
	logic [COL_W-1:0]  wm1_q;
	logic [ROW_W-1:0]  hm1_q;

	// Stream position.
	logic [COL_W-1:0]  in_col_q, emit_col_q;
	logic [ROW_W-1:0]  in_row_q, emit_row_q;
	logic [RING_W-1:0] in_ring_q, emit_ring_q;
	logic              drain_q;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [KW_W-1:0]   ky_q, kx_q;
	logic [CA_W-1:0]   cidx_q;
	result_t           pend_q, out_q, pend_out;
	logic              pend_valid_q, out_valid_q;

	logic              tap_v_s1;
	logic [RGB_W-1:0]  pix_s1;
	logic signed [COEF_W-1:0] coef_s1;
	logic signed [ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;

	logic [COEF_W-1:0] coef_mem [CA_DEPTH];
	logic [RGB_W-1:0]  row_mem  [RA_DEPTH];

	logic [KW_W-1:0]   cx, cy;
	logic [ROWX_W-1:0] by_raw, by;
	logic [COLX_W-1:0] bx_raw, bx;
	logic              out_rdy;

	logic signed [DS_W-1:0]   dy, dx;
	logic signed [ROWS_W-1:0] py, py_cl, d_row;
	logic signed [COLS_W-1:0] px, px_cl;
	logic signed [RS_W-1:0]   ring_sum;
	logic [RING_W-1:0]        ring;
	logic [RA_W-1:0]          rd_addr, wr_addr;

	logic              coef_we, row_we, slot_free, more, tap_last, cfg_we;
	logic [PIX_W-1:0]  red_rs, green_rs, blue_rs;

	assign cx = kw_q >> 1;
	assign cy = kh_q >> 1;

	// Bottom-right corner of the current output's window, clamped to the frame.
	always_comb begin
		by_raw  = {1'b0, emit_row_q} + ROWX_W'(kh_q - KW_W'(1) - cy);
		bx_raw  = {1'b0, emit_col_q} + COLX_W'(kw_q - KW_W'(1) - cx);
		by      = (by_raw > {1'b0, hm1_q}) ? {1'b0, hm1_q} : by_raw;
		bx      = (bx_raw > {1'b0, wm1_q}) ? {1'b0, wm1_q} : bx_raw;
		out_rdy = drain_q || (by < {1'b0, in_row_q}) ||
			((by == {1'b0, in_row_q}) && (bx < {1'b0, in_col_q}));
	end

	// Tap address: clamp to the frame, then find the ring row from the emit row's slot.
	always_comb begin
		dy    = $signed({1'b0, ky_q}) - $signed({1'b0, cy});
		dx    = $signed({1'b0, kx_q}) - $signed({1'b0, cx});
		py    = $signed({2'b00, emit_row_q}) + ROWS_W'(dy);
		px    = $signed({2'b00, emit_col_q}) + COLS_W'(dx);
		if (py < 0) begin
			py_cl = '0;
		end else if (py > $signed({2'b00, hm1_q})) begin
			py_cl = $signed({2'b00, hm1_q});
		end else begin
			py_cl = py;
		end
		if (px < 0) begin
			px_cl = '0;
		end else if (px > $signed({2'b00, wm1_q})) begin
			px_cl = $signed({2'b00, wm1_q});
		end else begin
			px_cl = px;
		end
		d_row    = py_cl - $signed({2'b00, emit_row_q});
		ring_sum = $signed({2'b00, emit_ring_q}) + RS_W'(d_row);
		if (ring_sum < 0) begin
			ring = RING_W'(ring_sum + RS_W'(MAX_KERNEL));
		end else if (ring_sum >= RS_W'(MAX_KERNEL)) begin
			ring = RING_W'(ring_sum - RS_W'(MAX_KERNEL));
		end else begin
			ring = RING_W'(ring_sum);
		end
		rd_addr = RA_W'(ring) * RA_W'(MAX_WIDTH) + RA_W'(COL_W'(px_cl));
		wr_addr = RA_W'(in_ring_q) * RA_W'(MAX_WIDTH) + RA_W'(in_col_q);
	end

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign coef_we   = q_pop && (q_item.cmd == CMD_COEF);
	assign row_we    = q_pop && (q_item.cmd == CMD_PIXEL) && !drain_q;
	assign slot_free = !out_valid_q || res_ready;
	assign more      = out_rdy && (cnt_q < CNT_W'(MAX_OUT));
	assign tap_last  = (kx_q == kw_q - KW_W'(1)) && (ky_q == kh_q - KW_W'(1));
	assign red_rs    = round_sat(acc_r_q);
	assign green_rs  = round_sat(acc_g_q);
	assign blue_rs   = round_sat(acc_b_q);
	assign res       = out_q;
	assign res_valid = out_valid_q;

	// Hand-off copy of the pending result, tagged last when no more follow.
	always_comb begin
		pend_out      = pend_q;
		pend_out.last = !more;
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[CA_W'(q_item.cidx)] <= q_item.coef;
		end
		coef_s1 <= coef_mem[cidx_q];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[wr_addr] <= q_item.rgb;
		end
		pix_s1 <= row_mem[rd_addr];
	end

	// Multiply-accumulate one tap per cycle, in the cycle after the reads.
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (tap_v_s1) begin
			acc_r_q <= acc_r_q + ACC_W'($signed({1'b0, pix_s1[3*PIX_W-1:2*PIX_W]}) * coef_s1);
			acc_g_q <= acc_g_q + ACC_W'($signed({1'b0, pix_s1[2*PIX_W-1:PIX_W]}) * coef_s1);
			acc_b_q <= acc_b_q + ACC_W'($signed({1'b0, pix_s1[PIX_W-1:0]}) * coef_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q         <= KW_W'(clamp_int(KCOLS_RST, 1, MAX_KERNEL));
			kh_q         <= KW_W'(clamp_int(KROWS_RST, 1, MAX_KERNEL));
			wm1_q        <= COL_W'(clamp_int(FWIDTH_RST, 1, MAX_WIDTH) - 1);
			hm1_q        <= ROW_W'(clamp_int(FHEIGHT_RST, 1, MAX_HEIGHT) - 1);
			in_col_q     <= '0;
			in_row_q     <= '0;
			in_ring_q    <= '0;
			emit_col_q   <= '0;
			emit_row_q   <= '0;
			emit_ring_q  <= '0;
			drain_q      <= 1'b0;
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ky_q         <= '0;
			kx_q         <= '0;
			cidx_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			tap_v_s1     <= 1'b0;
		end else begin
			tap_v_s1 <= (state_q == S_TAP);
			if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				// Any register write restarts the stream.
				unique case (cfg_reg_t'(cfg_index))
					REG_KCOLS:   kw_q  <= KW_W'(clamp_int(int'(cfg_data[2:0]), 1, MAX_KERNEL));
					REG_KROWS:   kh_q  <= KW_W'(clamp_int(int'(cfg_data[2:0]), 1, MAX_KERNEL));
					REG_FWIDTH:  wm1_q <= COL_W'(clamp_int(int'(cfg_data[10:0]), 1, MAX_WIDTH) - 1);
					REG_FHEIGHT: hm1_q <= ROW_W'(clamp_int(int'(cfg_data), 1, MAX_HEIGHT) - 1);
				endcase
				in_col_q    <= '0;
				in_row_q    <= '0;
				in_ring_q   <= '0;
				emit_col_q  <= '0;
				emit_row_q  <= '0;
				emit_ring_q <= '0;
				drain_q     <= 1'b0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						cnt_q <= '0;
						if (q_pop && (q_item.cmd == CMD_PIXEL || q_item.cmd == CMD_DRAIN)) begin
							state_q <= S_CHECK;
						end
						if (row_we) begin
							if (in_col_q == wm1_q) begin
								in_col_q <= '0;
								if (in_row_q == hm1_q) begin
									in_row_q  <= '0;
									in_ring_q <= '0;
									drain_q   <= 1'b1;
								end else begin
									in_row_q  <= in_row_q + 1'b1;
									in_ring_q <= (in_ring_q == RING_W'(MAX_KERNEL - 1)) ?
										'0 : in_ring_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
					end
					S_CHECK: begin
						// Hold the finished result until the output slot frees.
						if (!pend_valid_q || slot_free) begin
							if (pend_valid_q) begin
								out_q        <= pend_out;
								out_valid_q  <= 1'b1;
								pend_valid_q <= 1'b0;
							end
							if (more) begin
								ky_q    <= '0;
								kx_q    <= '0;
								cidx_q  <= '0;
								state_q <= S_TAP;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
					S_TAP: begin
						cidx_q <= cidx_q + 1'b1;
						if (kx_q == kw_q - KW_W'(1)) begin
							kx_q <= '0;
							ky_q <= ky_q + 1'b1;
						end else begin
							kx_q <= kx_q + 1'b1;
						end
						if (tap_last) begin
							state_q <= S_WAIT;
						end
					end
					S_WAIT: begin
						state_q <= S_FIN;
					end
					S_FIN: begin
						pend_q.col        <= COL_OUT_W'(emit_col_q);
						pend_q.row        <= emit_row_q;
						pend_q.red        <= red_rs;
						pend_q.green      <= green_rs;
						pend_q.blue       <= blue_rs;
						pend_q.frame_done <= (emit_col_q == wm1_q) && (emit_row_q == hm1_q);
						pend_q.last       <= 1'b0;
						pend_valid_q      <= 1'b1;
						cnt_q             <= cnt_q + 1'b1;
						state_q           <= S_CHECK;
						if (emit_col_q == wm1_q) begin
							emit_col_q <= '0;
							if (emit_row_q == hm1_q) begin
								emit_row_q  <= '0;
								emit_ring_q <= '0;
								drain_q     <= 1'b0;
							end else begin
								emit_row_q  <= emit_row_q + 1'b1;
								emit_ring_q <= (emit_ring_q == RING_W'(MAX_KERNEL - 1)) ?
									'0 : emit_ring_q + 1'b1;
							end
						end else begin
							emit_col_q <= emit_col_q + 1'b1;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

// ===== design/c2d_checker.sv =====
`include "conv2d_clamp_edge_rgb_assert.svh"

module c2d_checker import c2d_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COL_OUT_W-1:0] out_col,
	input logic [ROW_W-1:0]     out_row,
	input logic [PIX_W-1:0]     red_out,
	input logic [PIX_W-1:0]     green_out,
	input logic [PIX_W-1:0]     blue_out,
	input logic                 frame_done,
	input logic                 last
);

	logic [COL_OUT_W-1:0] prev_col_q;
	logic [ROW_W-1:0]     prev_row_q;
	logic                 seen_q;

	// Track the last accepted position; a register write restarts the raster.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			prev_col_q <= '0;
			prev_row_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			seen_q     <= 1'b1;
			prev_col_q <= out_col;
			prev_row_q <= out_row;
		end
	end

	`C2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_col) && $stable(out_row) && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_done) && $stable(last))
	`C2D_ASSERT_NOW(a_done_last, out_valid && frame_done, last)
	`C2D_ASSERT_NOW(a_raster, out_valid && out_ready && seen_q, ((out_col == prev_col_q + 1'b1) && (out_row == prev_row_q)) || ((out_col == '0) && ((out_row == prev_row_q + 1'b1) || (out_row == '0))))

endmodule

bind conv2d_clamp_edge_rgb c2d_checker u_c2d_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
	import c2d_pkg::*;

	// Longest quiet stretch tolerated: many times what four results of a 7x7
	// kernel take, plus receiver stalls.
	localparam int QUIET_LIMIT = 6000;
	// Block may still chew on a no-result beat after the last result arrives.
	localparam int SETTLE_CYCLES = 300;
	localparam int LINE_DEPTH = MAX_KERNEL_DEF * MAX_WIDTH_DEF;
	localparam int TAPS = MAX_KERNEL_DEF * MAX_KERNEL_DEF;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic [CIDX_W-1:0]        cidx;
		logic signed [COEF_W-1:0] cval;
		logic [PIX_W-1:0]         r;
		logic [PIX_W-1:0]         g;
		logic [PIX_W-1:0]         b;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          op = '0;
	logic [CIDX_W-1:0]        coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic [PIX_W-1:0]         red_in = '0;
	logic [PIX_W-1:0]         green_in = '0;
	logic [PIX_W-1:0]         blue_in = '0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COL_OUT_W-1:0] out_col;
	logic [ROW_W-1:0]     out_row;
	logic [PIX_W-1:0]     red_out;
	logic [PIX_W-1:0]     green_out;
	logic [PIX_W-1:0]     blue_out;
	logic                 frame_done;
	logic                 last;

	conv2d_clamp_edge_rgb u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_col    (out_col),
		.out_row    (out_row),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_done (frame_done),
		.last       (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the filter: its own coefficient and line stores, stream
	// positions and register copies.
	// ------------------------------------------------------------------
	logic [COEF_W-1:0] taps_mem [TAPS];
	logic [RGB_W-1:0]  lines_mem [LINE_DEPTH];
	int unsigned wr_col, wr_row, rd_col, rd_row;
	bit          flushing;
	int unsigned reg_kc = KCOLS_RST, reg_kr = KROWS_RST;
	int unsigned reg_fw = FWIDTH_RST, reg_fh = FHEIGHT_RST;

	beat_t   pending_beats [$];
	result_t owed_pixels [$];

	int pushed_n, taken_n, pixels_seen, mismatches, frames_run;
	int send_idle_pct = 19, recv_idle_pct = 49;

	function automatic int unsigned sat_range(int unsigned v, int unsigned hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic int unsigned eff_kc();
		return sat_range(reg_kc, MAX_KERNEL_DEF);
	endfunction
	function automatic int unsigned eff_kr();
		return sat_range(reg_kr, MAX_KERNEL_DEF);
	endfunction
	function automatic int unsigned eff_fw();
		return sat_range(reg_fw, MAX_WIDTH_DEF);
	endfunction
	function automatic int unsigned eff_fh();
		return sat_range(reg_fh, MAX_HEIGHT);
	endfunction

	function automatic void restart_stream();
		wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
		flushing = 0;
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, int unsigned data);
		case (idx)
			REG_KCOLS:   reg_kc = data & 32'h7;
			REG_KROWS:   reg_kr = data & 32'h7;
			REG_FWIDTH:  reg_fw = data & 32'h7FF;
			REG_FHEIGHT: reg_fh = data & 32'h1FFF;
			default: ;
		endcase
		restart_stream();
	endfunction

	// Has the bottom-right pixel of the next window arrived?
	function automatic bit window_complete();
		int unsigned kc, kr, by, bx;
		kc = eff_kc();
		kr = eff_kr();
		if (flushing)
			return 1;
		by = rd_row + (kr - 1 - kr / 2);
		bx = rd_col + (kc - 1 - kc / 2);
		if (by > eff_fh() - 1) by = eff_fh() - 1;
		if (bx > eff_fw() - 1) bx = eff_fw() - 1;
		return (by < wr_row) || (by == wr_row && bx < wr_col);
	endfunction

	function automatic logic [PIX_W-1:0] round_clip(longint acc);
		longint m;
		if (acc <= 0)
			return '0;
		m = (acc + 128) >>> 8;
		return (m > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : m[PIX_W-1:0];
	endfunction

	function automatic result_t filter_next();
		result_t res;
		int kc, kr, fw, fh, py, px;
		longint sr, sg, sb, c;
		logic [RGB_W-1:0] pix;
		kc = eff_kc(); kr = eff_kr(); fw = eff_fw(); fh = eff_fh();
		sr = 0; sg = 0; sb = 0;
		for (int ky = 0; ky < kr; ky++) begin
			py = int'(rd_row) + ky - kr / 2;
			py = (py < 0) ? 0 : ((py > fh - 1) ? fh - 1 : py);
			for (int kx = 0; kx < kc; kx++) begin
				px = int'(rd_col) + kx - kc / 2;
				px = (px < 0) ? 0 : ((px > fw - 1) ? fw - 1 : px);
				pix = lines_mem[(py % MAX_KERNEL_DEF) * MAX_WIDTH_DEF + px];
				c = longint'($signed(taps_mem[ky * kc + kx]));
				sr += longint'(pix[23:16]) * c;
				sg += longint'(pix[15:8]) * c;
				sb += longint'(pix[7:0]) * c;
			end
		end
		res.col = rd_col[COL_OUT_W-1:0];
		res.row = rd_row[ROW_W-1:0];
		res.red = round_clip(sr);
		res.green = round_clip(sg);
		res.blue = round_clip(sb);
		res.frame_done = 1'b0;
		res.last = 1'b0;
		rd_col++;
		if (rd_col >= fw) begin
			rd_col = 0;
			rd_row++;
			if (rd_row >= fh) begin
				rd_row = 0;
				res.frame_done = 1'b1;
				flushing = 0;
			end
		end
		return res;
	endfunction

	function automatic void absorb_beat(beat_t bt);
		int n;
		result_t res;
		n = 0;
		if (bt.op == OP_COEF) begin
			if (bt.cidx < TAPS)
				taps_mem[bt.cidx] = bt.cval;
			return;
		end
		if (bt.op == OP_NONE)
			return;
		if (bt.op == OP_PIXEL && !flushing) begin
			lines_mem[(wr_row % MAX_KERNEL_DEF) * MAX_WIDTH_DEF + wr_col] = {bt.r, bt.g, bt.b};
			wr_col++;
			if (wr_col >= eff_fw()) begin
				wr_col = 0;
				wr_row++;
				if (wr_row >= eff_fh()) begin
					wr_row = 0;
					flushing = 1;
				end
			end
		end
		while (n < MAX_OUT && window_complete()) begin
			res = filter_next();
			owed_pixels.push_back(res);
			n++;
		end
		// Tag the final result of this beat.
		if (n > 0)
			owed_pixels[owed_pixels.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Input driver: present the next queued beat, idle at random, hold
	// the payload steady while the block stalls.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				op <= pending_beats[0].op;
				coef_index <= pending_beats[0].cidx;
				coef_value <= pending_beats[0].cval;
				red_in <= pending_beats[0].r;
				green_in <= pending_beats[0].g;
				blue_in <= pending_beats[0].b;
				void'(pending_beats.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict on every accepted input beat.
	always @(posedge clk) begin
		beat_t bt;
		if (arst_n && in_valid && in_ready) begin
			bt.op = op;
			bt.cidx = coef_index;
			bt.cval = coef_value;
			bt.r = red_in;
			bt.g = green_in;
			bt.b = blue_in;
			absorb_beat(bt);
			taken_n++;
		end
	end

	// Receiver: stall at random, check each result beat against the oldest
	// expected pixel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			pixels_seen++;
			if (owed_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: col %0d row %0d rgb %0d/%0d/%0d",
						out_col, out_row, red_out, green_out, blue_out);
			end else begin
				want = owed_pixels.pop_front();
				if (out_col !== want.col || out_row !== want.row || red_out !== want.red ||
					green_out !== want.green || blue_out !== want.blue ||
					frame_done !== want.frame_done || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp col %0d row %0d rgb %0d/%0d/%0d fd %0b last %0b,",
							" got col %0d row %0d rgb %0d/%0d/%0d fd %0b last %0b"},
							want.col, want.row, want.red, want.green, want.blue,
							want.frame_done, want.last, out_col, out_row, red_out,
							green_out, blue_out, frame_done, last);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_beat(logic [OP_W-1:0] o, int unsigned ci, int unsigned cv,
		int unsigned r, int unsigned g, int unsigned b);
		beat_t bt;
		bt.op = o;
		bt.cidx = ci[CIDX_W-1:0];
		bt.cval = cv[COEF_W-1:0];
		bt.r = r[PIX_W-1:0];
		bt.g = g[PIX_W-1:0];
		bt.b = b[PIX_W-1:0];
		pending_beats.push_back(bt);
		pushed_n++;
	endtask

	task automatic queue_coef(int unsigned ci, int unsigned cv);
		queue_beat(OP_COEF, ci, cv, $urandom, $urandom, $urandom);
	endtask

	task automatic queue_pixel(int unsigned r, int unsigned g, int unsigned b);
		queue_beat(OP_PIXEL, $urandom, $urandom, r, g, b);
	endtask

	function automatic int unsigned rand_channel();
		case ($urandom_range(7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Mostly modest Q8.8 weights so sums land inside 0..255; some extremes.
	function automatic int unsigned rand_weight(int unsigned ntaps);
		int w;
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return $urandom_range(16'hFFFF);
			default: begin
				w = $urandom_range(0, 2 * 320 / ntaps) - 64 / ntaps;
				return w & 32'hFFFF;
			end
		endcase
	endfunction

	// Receiver idles more at first, then the sender, then neither.
	function automatic void set_idle_phase();
		if (pushed_n > 175) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end else if (pushed_n > 90) begin
			send_idle_pct = 49;
			recv_idle_pct = 19;
		end
	endfunction

	// Register write; the block is idle whenever this is called.
	task automatic write_reg(cfg_reg_t idx, int unsigned data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, data);
	endtask

	// Wait until every queued beat is taken and every result is back, then
	// let the block finish any beat that yields nothing.
	task automatic settle();
		while (taken_n != pushed_n || owed_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One frame: program the geometry, load the taps, stream pixels with
	// some noise mixed in, then flush the bottom rows.
	task automatic run_frame(int unsigned kc, int unsigned kr, int unsigned fw,
		int unsigned fh, int unsigned npix);
		int unsigned ekc, ekr, efw, efh, ntaps, nflush;
		set_idle_phase();
		write_reg(REG_KCOLS, kc);
		write_reg(REG_KROWS, kr);
		write_reg(REG_FWIDTH, fw);
		write_reg(REG_FHEIGHT, fh);
		ekc = eff_kc(); ekr = eff_kr(); efw = eff_fw(); efh = eff_fh();
		ntaps = ekc * ekr;
		for (int i = 0; i < ntaps; i++)
			queue_coef(i, rand_weight(ntaps));
		for (int p = 0; p < npix; p++) begin
			if ($urandom_range(99) < 10) begin
				case ($urandom_range(3))
					0: queue_beat(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
					1: queue_coef($urandom_range(TAPS, 63), $urandom);
					2: queue_coef($urandom_range(ntaps - 1), rand_weight(ntaps));
					default: queue_beat(OP_DRAIN, $urandom, $urandom, $urandom, $urandom,
						$urandom);
				endcase
			end
			queue_pixel(rand_channel(), rand_channel(), rand_channel());
		end
		// Pixels sent while flushing must act as drain beats. A partial frame
		// owes nothing, so a couple of idle drains cover it.
		nflush = efw * ((ekr - 1) / 2 + 1) / 4 + 2;
		if (npix < efw * efh)
			nflush = 2;
		for (int d = 0; d < nflush; d++) begin
			if ($urandom_range(3) == 0)
				queue_pixel(rand_channel(), rand_channel(), rand_channel());
			else
				queue_beat(OP_DRAIN, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
		frames_run++;
		settle();
	endtask

	initial begin
		int unsigned kc, kr, fw, fh;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: 1x1 kernel on a 2x2 frame; identity, negative and
		// saturating weights, half-way rounding, ignored ops and indexes.
		write_reg(REG_KCOLS, 1);
		write_reg(REG_KROWS, 1);
		write_reg(REG_FWIDTH, 2);
		write_reg(REG_FHEIGHT, 2);
		queue_coef(0, 16'h0100);
		queue_pixel(0, 0, 0);
		queue_beat(OP_NONE, 63, 16'hFFFF, 255, 255, 255);
		queue_coef(63, 16'h1234);
		queue_pixel(255, 255, 255);
		queue_coef(0, 16'h8000);
		queue_pixel(17, 200, 3);
		queue_coef(0, 16'h7FFF);
		queue_pixel(1, 2, 3);
		queue_beat(OP_DRAIN, 0, 0, 0, 0, 0);
		queue_coef(0, 16'h0080);
		queue_pixel(1, 3, 5);
		queue_pixel(0, 255, 2);
		queue_coef(0, 16'hFF80);
		queue_pixel(9, 9, 9);
		queue_pixel(255, 0, 255);
		settle();

		// Register extremes: zero sizes saturate up, oversize ones down,
		// the full 7x7 kernel, and a partial row on the widest frame.
		run_frame(0, 7, 0, 0, 3);
		run_frame(7, 7, 3, 3, 9);
		run_frame(7, 1, 2047, 8191, 40);
		run_frame(8, 15, 1024, 4096, 12);

		// Random small frames; idling moves to the next phase between frames.
		while (pushed_n < 250) begin
			kc = $urandom_range(7);
			kr = $urandom_range(7);
			fw = $urandom_range(0, 6);
			fh = $urandom_range(0, 11);
			run_frame(kc, kr, fw, fh, sat_range(fw, 1024) * sat_range(fh, 4096));
		end

		settle();
		$display("covered %0d input beats over %0d frames, %0d filtered pixels checked",
			pushed_n, frames_run, pixels_seen);
		$display("kernels 1x1 to 7x7, clamped borders, frame extremes and flush beats");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/c2d_pkg.sv
design/c2d_front.sv
design/c2d_back.sv
design/conv2d_clamp_edge_rgb.sv
design/c2d_checker.sv
tb/testbench.sv
